@@ sv/ciw_pkg.sv @@
// ciw_pkg: shared types and constants for the completion id window.
// Used by ciw_cell, ciw_hit_tree and completion_id_window. No dependencies.
package ciw_pkg;

    localparam int DEPTH_DEF    = 64;
    localparam int ID_WIDTH_DEF = 32;
    localparam int GRP_SIZE     = 8;

    localparam logic [1:0] OP_PUSH  = 2'd0;
    localparam logic [1:0] OP_QUERY = 2'd1;
    localparam logic [1:0] OP_ERASE = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SHIFT,
        S_QRY1,
        S_QRY2,
        S_DONE
    } t_state;

    typedef struct packed {
        logic push;
        logic shift;
        logic mark;
    } t_cell_cmd;

endpackage

@@ sv/ciw_cell.sv @@
// ciw_cell: one slot of the window chain; holds a valid flag, an erased flag and an id.
// Shifts toward the head on command. Depends on ciw_pkg.
module ciw_cell
    import ciw_pkg::*;
#(
    parameter int ID_WIDTH = ID_WIDTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cell_cmd           i_cmd,
    input  logic [ID_WIDTH-1:0] i_id,
    input  logic                i_prev_valid,
    input  logic                i_nxt_valid,
    input  logic                i_nxt_erased,
    input  logic [ID_WIDTH-1:0] i_nxt_id,
    output logic                o_valid,
    output logic                o_erased,
    output logic [ID_WIDTH-1:0] o_id,
    output logic                o_hit
);

    logic                r_valid;
    logic                r_erased;
    logic [ID_WIDTH-1:0] r_id;
    logic                r_hit;
    logic                w_match;

    assign w_match = (r_id == i_id);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_cmd.shift) begin
            r_valid <= i_nxt_valid;
        end else if (i_cmd.push && !r_valid && i_prev_valid) begin
            r_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.shift) begin
            r_erased <= i_nxt_erased;
            r_id     <= i_nxt_id;
        end else if (i_cmd.push && !r_valid && i_prev_valid) begin
            r_erased <= 1'b0;
            r_id     <= i_id;
        end else if (i_cmd.mark && r_valid && w_match) begin
            r_erased <= 1'b1;
        end
        r_hit <= r_valid && !r_erased && w_match;
    end

    assign o_valid  = r_valid;
    assign o_erased = r_erased;
    assign o_id     = r_id;
    assign o_hit    = r_hit;

endmodule

@@ sv/ciw_hit_tree.sv @@
// ciw_hit_tree: two-level registered OR of the per-cell query hits.
// Depends on ciw_pkg.
module ciw_hit_tree
    import ciw_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic [DEPTH-1:0] i_hits,
    output logic             o_any
);

    localparam int NGRP = (DEPTH + GRP_SIZE - 1) / GRP_SIZE;

    logic [NGRP*GRP_SIZE-1:0] w_pad;
    logic [NGRP-1:0]          n_grp;
    logic [NGRP-1:0]          r_grp;
    logic                     r_any;

    assign w_pad = (NGRP*GRP_SIZE)'(i_hits);

    always_comb begin
        for (int g = 0; g < NGRP; g++) begin
            n_grp[g] = |w_pad[g*GRP_SIZE +: GRP_SIZE];
        end
    end

    always_ff @(posedge i_clk) begin
        r_grp <= n_grp;
        r_any <= |r_grp;
    end

    assign o_any = r_any;

endmodule

@@ sv/completion_id_window.sv @@
// completion_id_window: ordered window of finished task ids built as a chain of cells.
// Depends on ciw_pkg, ciw_cell, ciw_hit_tree.
//
//  channel | valid   | stall   | payload
//  --------+---------+---------+------------------------------
//  in      | i_valid | o_stall | i_op, i_task_id
//  out     | o_valid | i_stall | o_found, o_status, o_occupancy
//
// Push, non-head erase and idle codes pass the exec and done states; a query also
// passes the two query states (hit OR tree). An erase at the head passes the shift
// state, which shifts out further erased entries; the chain moves one slot per cycle.
// One transfer is in work at a time; o_stall is high outside the idle state.
// A result waits in the done state while the output register is stalled.
// Reset is synchronous and empties the window.
module completion_id_window
    import ciw_pkg::*;
#(
    parameter int DEPTH    = DEPTH_DEF,
    parameter int ID_WIDTH = ID_WIDTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [1:0]                 i_op,
    input  logic [31:0]                i_task_id,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic                       o_found,
    output logic                       o_status,
    output logic [$clog2(DEPTH+1)-1:0] o_occupancy
);

    localparam int CW = $clog2(DEPTH + 1);

    t_state              r_state, n_state;
    logic [1:0]          r_op;
    logic [ID_WIDTH-1:0] r_id;
    logic [CW-1:0]       r_count, n_count;
    logic                r_status_p, n_status_p;
    logic                r_out_valid, n_out_valid;
    logic                r_found, r_status;
    logic [CW-1:0]       r_occ;
    logic                w_load;
    logic                w_any;
    logic                w_full;
    logic                w_head_hit;
    t_cell_cmd           w_cmd;

    logic [DEPTH-1:0]    w_valid;
    logic [DEPTH-1:0]    w_erased;
    logic [ID_WIDTH-1:0] w_id [DEPTH];
    logic [DEPTH-1:0]    w_hits;

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic                c_prev_valid;
        logic                c_nxt_valid;
        logic                c_nxt_erased;
        logic [ID_WIDTH-1:0] c_nxt_id;

        if (i == 0) begin : g_first
            assign c_prev_valid = 1'b1;
        end else begin : g_rest
            assign c_prev_valid = w_valid[i-1];
        end

        if (i == DEPTH - 1) begin : g_last
            assign c_nxt_valid  = 1'b0;
            assign c_nxt_erased = 1'b0;
            assign c_nxt_id     = '0;
        end else begin : g_mid
            assign c_nxt_valid  = w_valid[i+1];
            assign c_nxt_erased = w_erased[i+1];
            assign c_nxt_id     = w_id[i+1];
        end

        ciw_cell #(
            .ID_WIDTH(ID_WIDTH)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_cmd       (w_cmd),
            .i_id        (r_id),
            .i_prev_valid(c_prev_valid),
            .i_nxt_valid (c_nxt_valid),
            .i_nxt_erased(c_nxt_erased),
            .i_nxt_id    (c_nxt_id),
            .o_valid     (w_valid[i]),
            .o_erased    (w_erased[i]),
            .o_id        (w_id[i]),
            .o_hit       (w_hits[i])
        );
    end

    ciw_hit_tree #(
        .DEPTH(DEPTH)
    ) u_tree (
        .i_clk (i_clk),
        .i_hits(w_hits),
        .o_any (w_any)
    );

    assign w_full     = (r_count == CW'(DEPTH));
    assign w_head_hit = (r_count != '0) && (w_id[0] == r_id);
    assign w_load     = (r_state == S_DONE) && (!r_out_valid || !i_stall);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) n_state = S_EXEC;
            end
            S_EXEC: begin
                if (r_op == OP_QUERY) begin
                    n_state = S_QRY1;
                end else if (r_op == OP_ERASE && w_head_hit) begin
                    n_state = S_SHIFT;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_SHIFT: begin
                if (!(r_count != '0 && w_erased[0])) n_state = S_DONE;
            end
            S_QRY1:  n_state = S_QRY2;
            S_QRY2:  n_state = S_DONE;
            S_DONE: begin
                if (!r_out_valid || !i_stall) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs and datapath control
    always_comb begin
        w_cmd      = '0;
        n_count    = r_count;
        n_status_p = r_status_p;
        unique case (r_state)
            S_IDLE: begin
                n_status_p = 1'b0;
            end
            S_EXEC: begin
                if (r_op == OP_PUSH) begin
                    if (w_full) begin
                        n_status_p = 1'b1;
                    end else begin
                        w_cmd.push = 1'b1;
                        n_count    = r_count + CW'(1);
                    end
                end else if (r_op == OP_ERASE && r_count != '0) begin
                    if (w_head_hit) begin
                        w_cmd.shift = 1'b1;
                        n_count     = r_count - CW'(1);
                    end else begin
                        w_cmd.mark = 1'b1;
                    end
                end
            end
            S_SHIFT: begin
                if (r_count != '0 && w_erased[0]) begin
                    w_cmd.shift = 1'b1;
                    n_count     = r_count - CW'(1);
                end
            end
            S_QRY1, S_QRY2, S_DONE: begin
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (r_out_valid && !i_stall) n_out_valid = 1'b0;
        if (w_load) n_out_valid = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_status_p  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_status_p  <= n_status_p;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_valid) begin
            r_op <= i_op;
            r_id <= ID_WIDTH'(i_task_id);
        end
        if (w_load) begin
            r_found  <= (r_op == OP_QUERY) && w_any;
            r_status <= r_status_p;
            r_occ    <= r_count;
        end
    end

    assign o_stall     = (r_state != S_IDLE);
    assign o_valid     = r_out_valid;
    assign o_found     = r_found;
    assign o_status    = r_status;
    assign o_occupancy = r_occ;

endmodule
